@@ rtl/fbt_pkg.sv @@
// ----------------------------------------------------------------------------
// fbt_pkg
// Shared constants, codes and defaults of the FNV-1a hashed bucket table.
// ----------------------------------------------------------------------------
package fbt_pkg;

  localparam int unsigned NUM_BUCKETS_DEF      = 128;
  localparam int unsigned SLOTS_PER_BUCKET_DEF = 8;
  localparam int unsigned VALUE_BITS_DEF       = 32;

  localparam int unsigned HASH_W      = 32;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_VALUE_W  = 32;
  localparam int unsigned OUT_VALUE_W = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2,
    STAT_ZERO = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

@@ rtl/fbt_if.sv @@
// ----------------------------------------------------------------------------
// fbt_if
// Request and response channels of the hashed bucket table.
// ----------------------------------------------------------------------------
interface fbt_req_if import fbt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [BYTE_W-1:0]     key_byte;
  logic                  last_byte;
  logic [IN_VALUE_W-1:0] insert_value;

  modport source (output valid, kind, key_byte, last_byte, insert_value, input ready);
  modport sink   (input valid, kind, key_byte, last_byte, insert_value, output ready);
endinterface

interface fbt_rsp_if import fbt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [OUT_VALUE_W-1:0] value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink   (input valid, status, value_out, output ready);
endinterface

@@ rtl/fbt_ram.sv @@
// ----------------------------------------------------------------------------
// fbt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fbt_mod_unit.sv @@
// ----------------------------------------------------------------------------
// fbt_mod_unit
// Remainder of a hash by a constant divisor: reciprocal multiply, back
// multiply and one correcting subtract, one step a cycle.
// ----------------------------------------------------------------------------
module fbt_mod_unit import fbt_pkg::*; #(
  parameter int unsigned DIVISOR = NUM_BUCKETS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [HASH_W-1:0]                             dividend_i,
  output logic                                          done_o,
  output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] rem_o
);

  localparam int unsigned REM_W  = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
  localparam int unsigned CALC_W = REM_W + 1;
  localparam int unsigned PROD_W = 2 * HASH_W;
  // floor(2^32 / DIVISOR); the quotient estimate is at most one short
  localparam logic [PROD_W-1:0] RECIP = PROD_W'((64'd1 << HASH_W) / 64'(DIVISOR));
  localparam logic [HASH_W-1:0] DIV_H = HASH_W'(DIVISOR);
  localparam logic [CALC_W-1:0] DIV_C = CALC_W'(DIVISOR);

  logic              s1_q, s2_q, s3_q, done_q;
  logic [HASH_W-1:0] dvd_q, dvd_d;
  logic [HASH_W-1:0] quo_q, quo_d;
  logic [CALC_W-1:0] est_q, est_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [PROD_W-1:0] prod;
  logic [HASH_W-1:0] diff;

  assign prod = PROD_W'(dvd_q) * RECIP;
  assign diff = dvd_q - (quo_q * DIV_H);

  always_comb begin
    dvd_d = dvd_q;
    quo_d = quo_q;
    est_d = est_q;
    rem_d = rem_q;
    if (start_i) begin
      dvd_d = dividend_i;
    end
    if (s1_q) begin
      quo_d = prod[PROD_W-1:HASH_W];
    end
    if (s2_q) begin
      est_d = diff[CALC_W-1:0];
    end
    if (s3_q) begin
      rem_d = (est_q >= DIV_C) ? REM_W'(est_q - DIV_C) : est_q[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      s3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      s3_q   <= s2_q;
      done_q <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    est_q <= est_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/fnv1a_hashed_bucket_table_top.sv @@
// ----------------------------------------------------------------------------
// fnv1a_hashed_bucket_table_top
// FNV-1a keyed hash table with fixed-size buckets of hashed keys.
// ----------------------------------------------------------------------------
// Requests on req_i carry one key byte each; a byte without last_byte folds
// into the running 32-bit FNV-1a hash, with no response.
// The request marked last_byte runs kind (insert, find, remove) and yields
// exactly one response on rsp_o with status and value_out.
// A last byte is taken, then the bucket index is formed (hash modulo
// NUM_BUCKETS by reciprocal multiply, back multiply and one correcting
// subtract in the modulo unit), then the bucket's SLOTS_PER_BUCKET slots
// are scanned through the key RAM read port, one slot a cycle, up to a
// match, and the response is staged. A zero hash or an unknown kind skips
// the modulo unit and the scan. req_i.ready is low meanwhile.
// After reset every slot of the key RAM is swept to empty, one slot a
// cycle, before the first request is taken.
// The response sits in an output register; a stalled receiver holds it
// there while key bytes are still taken, and a following last byte waits
// in its final cycle until the register is free.
// ----------------------------------------------------------------------------
module fnv1a_hashed_bucket_table_top import fbt_pkg::*; #(
  parameter int unsigned NUM_BUCKETS      = NUM_BUCKETS_DEF,
  parameter int unsigned SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
  parameter int unsigned VALUE_BITS       = VALUE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fbt_req_if.sink  req_i,
  fbt_rsp_if.source rsp_o
);

  localparam int unsigned TOTAL_SLOTS = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int unsigned ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned SLOT_W = $clog2(SLOTS_PER_BUCKET + 1);

  state_e                 state_q, state_d;
  logic [HASH_W-1:0]      hash_q, hash_d;
  logic [HASH_W-1:0]      hash_new;
  logic [HASH_W-1:0]      key_q, key_d;
  logic [KIND_W-1:0]      kind_q, kind_d;
  logic [VALUE_BITS-1:0]  ival_q, ival_d;
  logic [ADDR_W-1:0]      clr_q, clr_d;
  logic [ADDR_W-1:0]      base_q, base_d;
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic [SLOT_W-1:0]      pidx_q, pidx_d;
  logic                   pend_q, pend_d;
  status_e                res_status_q, res_status_d;
  logic [OUT_VALUE_W-1:0] res_value_q, res_value_d;
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [OUT_VALUE_W-1:0] out_value_q, out_value_d;

  logic                   accept;
  logic                   kind_ok;
  logic                   mod_start;
  logic                   mod_done;
  logic [BKT_W-1:0]       bucket;
  logic                   issue;
  logic                   hit;
  logic                   out_free;
  logic [HASH_W-1:0]      target;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      hit_addr;

  logic                   key_we;
  logic [ADDR_W-1:0]      key_waddr;
  logic [HASH_W-1:0]      key_wdata;
  logic [HASH_W-1:0]      key_rdata;
  logic                   val_we;
  logic [VALUE_BITS-1:0]  val_rdata;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign hash_new    = (hash_q ^ HASH_W'(req_i.key_byte)) * FNV_PRIME;
  assign kind_ok     = (req_i.kind == KIND_INSERT) || (req_i.kind == KIND_FIND) ||
                       (req_i.kind == KIND_REMOVE);

  assign issue    = (state_q == ST_SCAN) && (idx_q < SLOT_W'(SLOTS_PER_BUCKET));
  assign rd_addr  = base_q + ADDR_W'(idx_q);
  assign hit_addr = base_q + ADDR_W'(pidx_q);
  assign target   = (kind_q == KIND_INSERT) ? '0 : key_q;
  assign hit      = (state_q == ST_SCAN) && pend_q && (key_rdata == target);
  assign out_free = !out_valid_q || rsp_o.ready;

  fbt_mod_unit #(
    .DIVISOR (NUM_BUCKETS)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (hash_new),
    .done_o     (mod_done),
    .rem_o      (bucket)
  );

  fbt_ram #(
    .WIDTH (HASH_W),
    .DEPTH (TOTAL_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  fbt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TOTAL_SLOTS)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (hit_addr),
    .wdata_i (ival_q),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == ADDR_W'(TOTAL_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && req_i.last_byte) begin
          if ((hash_new == '0) || !kind_ok) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || !issue) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    hash_d       = hash_q;
    key_d        = key_q;
    kind_d       = kind_q;
    ival_d       = ival_q;
    clr_d        = clr_q;
    base_d       = base_q;
    idx_d        = idx_q;
    pidx_d       = pidx_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    mod_start    = 1'b0;
    key_we       = 1'b0;
    key_waddr    = hit_addr;
    key_wdata    = '0;
    val_we       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.last_byte) begin
            hash_d      = FNV_BASIS;
            key_d       = hash_new;
            kind_d      = req_i.kind;
            ival_d      = VALUE_BITS'(req_i.insert_value);
            res_value_d = '0;
            if (hash_new == '0) begin
              res_status_d = STAT_ZERO;
            end else if (!kind_ok) begin
              res_status_d = STAT_MISS;
            end else begin
              mod_start = 1'b1;
            end
          end else begin
            hash_d = hash_new;
          end
        end
      end
      ST_MOD: begin
        base_d = ADDR_W'(bucket * SLOTS_PER_BUCKET);
        idx_d  = '0;
        pend_d = 1'b0;
      end
      ST_SCAN: begin
        pend_d = issue;
        pidx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (hit) begin
          res_status_d = STAT_OK;
          if (kind_q == KIND_INSERT) begin
            key_we      = 1'b1;
            key_wdata   = key_q;
            val_we      = 1'b1;
            res_value_d = '0;
          end else begin
            res_value_d = OUT_VALUE_W'(val_rdata);
            if (kind_q == KIND_REMOVE) begin
              key_we = 1'b1;
            end
          end
        end else if (!issue) begin
          res_status_d = (kind_q == KIND_INSERT) ? STAT_FULL : STAT_MISS;
          res_value_d  = '0;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      hash_q      <= FNV_BASIS;
      clr_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    kind_q       <= kind_d;
    ival_q       <= ival_d;
    base_q       <= base_d;
    pidx_q       <= pidx_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.value_out = out_value_q;

endmodule
